// ===== design/bcs_pkg.sv =====
// shared types and constants of the bigram categorical sampler
package bcs_pkg;

  localparam int SYMBOLS_DEF     = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int CTX_W    = 5;
  localparam int SYM_W    = 5;
  localparam int WEIGHT_W = 16;
  localparam int RAND_W   = 15;
  localparam int STATUS_W = 2;

  // draw scale is 2^15 - 1, applied as a shift and a subtract
  localparam logic [RAND_W-1:0] DRAW_SCALE = 15'h7fff;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERRUN = 2'd2;

  typedef struct packed {
    logic                command;
    logic [CTX_W-1:0]    context_req;
    logic [SYM_W-1:0]    symbol;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]   random_value;
  } bcs_in_t;

  typedef struct packed {
    logic [SYM_W-1:0]    chosen_symbol;
    logic [STATUS_W-1:0] status;
  } bcs_out_t;

endpackage

// ===== design/bcs_ram.sv =====
// single-port synchronous ram with registered read
module bcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bigram_categorical_sampler.sv =====
// top level of the bigram categorical sampler: weight table, row totals, sample walk
// load: busy through the ST_LDRD and ST_LDWR states after the accepting edge, no result
// sample: result strobe after the ST_TOT, ST_MUL and ST_WALK states,
//   set by the one-entry-per-cycle walk through the single-port weight memory
// empty row: result strobe from ST_MUL; row outside the table: strobe registered on accept
// reset: clearing sweep over all SYMBOLS*SYMBOLS weight memory entries, busy held high
// results cannot be stalled; a new item may be accepted while a result is shown
module bigram_categorical_sampler
  import bcs_pkg::*;
#(
  parameter int SYMBOLS     = SYMBOLS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bcs_in_t  item_i,
  output logic     done_o,
  output bcs_out_t result_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  localparam int RW    = $clog2(SYMBOLS);
  localparam int IW    = RW + 1;
  localparam int DEPTH = SYMBOLS * SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = WEIGHT_BITS + RW;
  localparam int SW    = TW + RAND_W;
  localparam int XW    = (RW > CTX_W) ? RW : CTX_W;
  localparam int LW    = (RW > SYM_W) ? RW : SYM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_LDRD  = 3'd2;
  localparam logic [2:0] ST_LDWR  = 3'd3;
  localparam logic [2:0] ST_TOT   = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_WALK  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic                   mode_q;
  logic [AW-1:0]          clr_q, clr_d;
  logic [RW-1:0]          row_q, row_d;
  logic [AW-1:0]          base_q, base_d;
  logic [AW-1:0]          waddr_q, waddr_d;
  logic [WEIGHT_BITS-1:0] wt_q, wt_d;
  logic [RAND_W-1:0]      rnd_q, rnd_d;
  logic [SW-1:0]          bound_q, bound_d;
  logic [SW-1:0]          sc_q, sc_d;
  logic [IW-1:0]          iss_q, iss_d;
  logic                   v1_q, v1_d, v2_q, v2_d;
  logic [RW-1:0]          idx1_q, idx1_d, idx2_q, idx2_d;
  logic                   done_q, done_d;
  bcs_out_t               res_q, res_d;

  logic                   w_we, t_we;
  logic [AW-1:0]          w_addr;
  logic [RW-1:0]          t_addr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic [TW-1:0]          t_wdata, t_rdata;

  logic [XW-1:0]          ctx_x;
  logic [LW-1:0]          sym_x;
  logic                   ctx_ok, sym_ok, row_ok;
  logic [RW-1:0]          ctx_row, sample_row;
  logic [SW-1:0]          w_ext, w_scaled;
  logic                   accept;

  bcs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_weights (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .addr_i (w_addr),
    .wdata_i(w_wdata),
    .rdata_o(w_rdata)
  );

  bcs_ram #(.WIDTH(TW), .DEPTH(SYMBOLS)) u_totals (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .addr_i (t_addr),
    .wdata_i(t_wdata),
    .rdata_o(t_rdata)
  );

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign ctx_x      = XW'(item_i.context_req);
  assign sym_x      = LW'(item_i.symbol);
  assign ctx_ok     = (32'(ctx_x) < SYMBOLS);
  assign sym_ok     = (32'(sym_x) < SYMBOLS);
  assign ctx_row    = RW'(ctx_x);
  assign sample_row = mode_q ? ctx_row : '0;
  assign row_ok     = mode_q ? ctx_ok : 1'b1;

  // weight times 32767 as (w << 15) - w
  assign w_ext    = SW'(w_rdata);
  assign w_scaled = (w_ext << RAND_W) - w_ext;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    row_d   = row_q;
    base_d  = base_q;
    waddr_d = waddr_q;
    wt_d    = wt_q;
    rnd_d   = rnd_q;
    bound_d = bound_q;
    sc_d    = sc_q;
    iss_d   = iss_q;
    v1_d    = 1'b0;
    v2_d    = 1'b0;
    idx1_d  = idx1_q;
    idx2_d  = idx2_q;
    done_d  = 1'b0;
    res_d   = res_q;
    w_we    = 1'b0;
    t_we    = 1'b0;
    w_addr  = waddr_q;
    t_addr  = row_q;
    w_wdata = wt_q;
    t_wdata = t_rdata - TW'(w_rdata) + TW'(wt_q);

    unique case (state_q)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_addr  = clr_q;
        w_wdata = '0;
        t_we    = (32'(clr_q) < SYMBOLS);
        t_addr  = RW'(clr_q);
        t_wdata = '0;
        clr_d   = clr_q + AW'(1);
        if (32'(clr_q) == DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rnd_d = item_i.random_value;
          wt_d  = WEIGHT_BITS'(item_i.weight);
          if (item_i.command == CMD_LOAD) begin
            row_d   = ctx_row;
            waddr_d = AW'(ctx_row) * AW'(SYMBOLS) + AW'(RW'(sym_x));
            if (ctx_ok && sym_ok) begin
              state_d = ST_LDRD;
            end
          end else begin
            row_d  = sample_row;
            base_d = AW'(sample_row) * AW'(SYMBOLS);
            if (row_ok) begin
              state_d = ST_TOT;
            end else begin
              done_d              = 1'b1;
              res_d.chosen_symbol = SYM_W'(SYMBOLS - 1);
              res_d.status        = STATUS_EMPTY;
            end
          end
        end
      end
      ST_LDRD: begin
        state_d = ST_LDWR;
      end
      ST_LDWR: begin
        w_we    = 1'b1;
        t_we    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TOT: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        bound_d = SW'(rnd_q) * SW'(t_rdata);
        sc_d    = '0;
        iss_d   = '0;
        if (t_rdata == '0) begin
          done_d              = 1'b1;
          res_d.chosen_symbol = SYM_W'(SYMBOLS - 1);
          res_d.status        = STATUS_EMPTY;
          state_d             = ST_IDLE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        w_addr = base_q + AW'(iss_q[RW-1:0]);
        if (32'(iss_q) < SYMBOLS) begin
          iss_d  = iss_q + IW'(1);
          v1_d   = 1'b1;
          idx1_d = iss_q[RW-1:0];
        end
        if (v1_q) begin
          sc_d   = sc_q + w_scaled;
          v2_d   = 1'b1;
          idx2_d = idx1_q;
        end
        if (v2_q) begin
          if (sc_q > bound_q) begin
            done_d              = 1'b1;
            res_d.chosen_symbol = SYM_W'(idx2_q);
            res_d.status        = STATUS_OK;
            state_d             = ST_IDLE;
          end else if (32'(idx2_q) == SYMBOLS - 1) begin
            done_d              = 1'b1;
            res_d.chosen_symbol = SYM_W'(SYMBOLS - 1);
            res_d.status        = STATUS_OVERRUN;
            state_d             = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      mode_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    base_q  <= base_d;
    waddr_q <= waddr_d;
    wt_q    <= wt_d;
    rnd_q   <= rnd_d;
    bound_q <= bound_d;
    sc_q    <= sc_d;
    iss_q   <= iss_d;
    idx1_q  <= idx1_d;
    idx2_q  <= idx2_d;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
